// ===== src/deq_pkg.sv =====
// Shared types and constants for the double-ended queue block.
// No dependencies; compile this file first.
package deq_pkg;

    localparam int CMD_W    = 3;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Command codes; the codes above CMD_PEEK act as a peek.
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL_ERR  = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0]   popped_value;
        logic [WORD_W-1:0]   front_value;
        logic [WORD_W-1:0]   back_value;
        logic [COUNT_W-1:0]  element_count;
        logic                is_empty;
        logic                is_full;
        logic [STATUS_W-1:0] status;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic take;    // command transfer this cycle
        logic finish;  // slot read has landed; complete the pending result
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic room;        // result queue can take one more result
        logic need_fetch;  // current command needs a slot read
    } ctl_stat_t;

endpackage

// ===== src/deq_if.sv =====
// Channel interfaces: command channel and result channel.
// Depends on deq_pkg.
interface deq_cmd_if;
    import deq_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [WORD_W-1:0]  data_in;

    modport source (output valid, output cmd, output data_in, input ready);
    modport sink (input valid, input cmd, input data_in, output ready);
endinterface

interface deq_res_if;
    import deq_pkg::*;

    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   popped_value;
    logic [WORD_W-1:0]   front_value;
    logic [WORD_W-1:0]   back_value;
    logic [COUNT_W-1:0]  element_count;
    logic                is_empty;
    logic                is_full;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, output popped_value, output front_value, output back_value,
        output element_count, output is_empty, output is_full, output status,
        input ready
    );
    modport sink (
        input valid, input popped_value, input front_value, input back_value,
        input element_count, input is_empty, input is_full, input status,
        output ready
    );
endinterface

// ===== src/double_ended_queue_top.sv =====
// A result is registered in the result queue after its command transfer; a pop that leaves
// elements behind first waits in S_FETCH, as the new end element is read from the slot memory.
// Throughput: one command per cycle while the result queue has room; a pop that leaves elements
// blocks input until its slot read has landed. Two results may wait at the output.
// Reset (rst_n, async, active low) clears head, count, sequencer and result queue;
// slot contents are not cleared and are only read once written.
module double_ended_queue_top
    import deq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input logic       clk,
    input logic       rst_n,
    deq_cmd_if.sink   req,
    deq_res_if.source rsp
);

    ctl_cmd_t  ctl;
    ctl_stat_t stat;
    result_t   rsp_data;

    // Sequencer: gates command transfers and marks the cycle a slot read lands
    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // Datapath: ring store, pointers, end caches, result queue
    deq_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .cmd       (req.cmd),
        .data_in   (req.data_in),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp_data)
    );

    // Unpack the head result onto the result channel
    assign rsp.popped_value  = rsp_data.popped_value;
    assign rsp.front_value   = rsp_data.front_value;
    assign rsp.back_value    = rsp_data.back_value;
    assign rsp.element_count = rsp_data.element_count;
    assign rsp.is_empty      = rsp_data.is_empty;
    assign rsp.is_full       = rsp_data.is_full;
    assign rsp.status        = rsp_data.status;

endmodule

// ===== src/deq_ctrl.sv =====
// Sequencer for the double-ended queue: takes commands and waits out slot reads.
// Depends on deq_pkg.
module deq_ctrl
    import deq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ctl_stat_t stat,
    output ctl_cmd_t  ctl
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_FETCH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready   = (state_reg == S_IDLE) && stat.room;
    assign ctl.take   = in_valid && in_ready;
    assign ctl.finish = (state_reg == S_FETCH);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.take && stat.need_fetch)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/deq_dpath.sv =====
// Datapath: slot ring, head and count, end caches and a two-entry result queue.
// Depends on deq_pkg.
module deq_dpath
    import deq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_cmd_t          ctl,
    output ctl_stat_t         stat,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [WORD_W-1:0] data_in,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output result_t           rsp_data
);

    localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(DEPTH - 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);
    localparam logic [CNTW:0]   DEPTH_W  = (CNTW + 1)'(DEPTH);

    logic [DATA_WIDTH-1:0] slot_mem [DEPTH];

    logic [IDXW-1:0]       head_reg;
    logic [IDXW-1:0]       head_next;
    logic [CNTW-1:0]       count_reg;
    logic [CNTW-1:0]       count_next;
    logic [DATA_WIDTH-1:0] front_reg;
    logic [DATA_WIDTH-1:0] front_next;
    logic [DATA_WIDTH-1:0] back_reg;
    logic [DATA_WIDTH-1:0] back_next;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [DATA_WIDTH-1:0] din;
    logic [DATA_WIDTH-1:0] popped;
    logic [STATUS_W-1:0]   status;

    logic                  wr_en;
    logic [IDXW-1:0]       wr_addr;
    logic [IDXW-1:0]       rd_addr;
    logic                  fetch_front;
    logic                  need_fetch;

    logic [IDXW-1:0]       head_inc;
    logic [IDXW-1:0]       head_dec;
    logic [CNTW:0]         tail_sum;
    logic [CNTW:0]         last_sum;
    logic [IDXW-1:0]       tail_idx;
    logic [IDXW-1:0]       last2_idx;
    logic                  is_empty_now;
    logic                  is_full_now;

    result_t               res_now;
    result_t               res_fetched;
    result_t               pend_reg;
    logic                  pend_front_reg;

    result_t               q_mem_reg [2];
    logic                  q_wr_reg;
    logic                  q_rd_reg;
    logic [1:0]            q_cnt_reg;
    logic                  enq;
    logic                  deq;
    result_t               enq_data;

    assign din          = DATA_WIDTH'(data_in);
    assign is_empty_now = (count_reg == '0);
    assign is_full_now  = (count_reg == FULL_CNT);

    // Ring positions; each sum that is used stays below twice the depth
    assign head_inc  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_dec  = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign tail_sum  = (CNTW + 1)'(head_reg) + (CNTW + 1)'(count_reg);
    assign last_sum  = tail_sum - (CNTW + 1)'(2);
    assign tail_idx  = IDXW'((tail_sum >= DEPTH_W) ? tail_sum - DEPTH_W : tail_sum);
    assign last2_idx = IDXW'((last_sum >= DEPTH_W) ? last_sum - DEPTH_W : last_sum);

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        front_next  = front_reg;
        back_next   = back_reg;
        popped      = '0;
        status      = ST_OK;
        wr_en       = 1'b0;
        wr_addr     = tail_idx;
        rd_addr     = head_inc;
        fetch_front = 1'b1;
        need_fetch  = 1'b0;
        unique case (cmd)
            CMD_PUSH_FRONT:
            begin
                if (is_full_now)
                begin
                    status = ST_FULL_ERR;
                end
                else
                begin
                    head_next  = head_dec;
                    wr_en      = 1'b1;
                    wr_addr    = head_dec;
                    count_next = count_reg + 1'b1;
                    front_next = din;
                    if (is_empty_now)
                    begin
                        back_next = din;
                    end
                end
            end
            CMD_PUSH_BACK:
            begin
                if (is_full_now)
                begin
                    status = ST_FULL_ERR;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    back_next  = din;
                    if (is_empty_now)
                    begin
                        front_next = din;
                    end
                end
            end
            CMD_POP_FRONT:
            begin
                if (is_empty_now)
                begin
                    status = ST_EMPTY_ERR;
                end
                else
                begin
                    popped     = front_reg;
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                    need_fetch = (count_reg != CNTW'(1));
                end
            end
            CMD_POP_BACK:
            begin
                if (is_empty_now)
                begin
                    status = ST_EMPTY_ERR;
                end
                else
                begin
                    popped      = back_reg;
                    count_next  = count_reg - 1'b1;
                    rd_addr     = last2_idx;
                    fetch_front = 1'b0;
                    need_fetch  = (count_reg != CNTW'(1));
                end
            end
            default:
            begin
                // Peek and unused codes leave everything as is
            end
        endcase
    end

    always_comb
    begin
        res_now.popped_value  = WORD_W'(popped);
        res_now.front_value   = (count_next == '0) ? '0 : WORD_W'(front_next);
        res_now.back_value    = (count_next == '0) ? '0 : WORD_W'(back_next);
        res_now.element_count = COUNT_W'(count_next);
        res_now.is_empty      = (count_next == '0);
        res_now.is_full       = (count_next == FULL_CNT);
        res_now.status        = status;

        res_fetched = pend_reg;
        if (pend_front_reg)
        begin
            res_fetched.front_value = WORD_W'(rd_data_reg);
        end
        else
        begin
            res_fetched.back_value = WORD_W'(rd_data_reg);
        end
    end

    // Slot ring: one write or one read per transfer, read data registered
    always_ff @(posedge clk)
    begin
        if (ctl.take && wr_en)
        begin
            slot_mem[wr_addr] <= din;
        end
        if (ctl.take && need_fetch)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (ctl.take)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // End caches and pending result; payload only
    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            front_reg      <= front_next;
            back_reg       <= back_next;
            pend_reg       <= res_now;
            pend_front_reg <= fetch_front;
        end
        else if (ctl.finish)
        begin
            if (pend_front_reg)
            begin
                front_reg <= rd_data_reg;
            end
            else
            begin
                back_reg <= rd_data_reg;
            end
        end
    end

    // Result queue
    assign enq       = (ctl.take && !need_fetch) || ctl.finish;
    assign enq_data  = ctl.finish ? res_fetched : res_now;
    assign rsp_valid = (q_cnt_reg != 2'd0);
    assign deq       = rsp_valid && rsp_ready;
    assign rsp_data  = q_mem_reg[q_rd_reg];
    assign stat      = '{room: (q_cnt_reg != 2'd2), need_fetch: need_fetch};

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_mem_reg[q_wr_reg] <= enq_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= 1'b0;
            q_rd_reg  <= 1'b0;
            q_cnt_reg <= 2'd0;
        end
        else
        begin
            if (enq)
            begin
                q_wr_reg <= ~q_wr_reg;
            end
            if (deq)
            begin
                q_rd_reg <= ~q_rd_reg;
            end
            q_cnt_reg <= q_cnt_reg + 2'(enq) - 2'(deq);
        end
    end

endmodule

// ===== src/deq_chk.sv =====
// Port-level checks on the result channel of the double-ended queue.
// Depends on deq_pkg; bound to double_ended_queue_top.
module deq_chk
    import deq_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [WORD_W-1:0]   popped_value,
    input logic [WORD_W-1:0]   front_value,
    input logic [WORD_W-1:0]   back_value,
    input logic                is_empty,
    input logic                is_full,
    input logic [STATUS_W-1:0] status
);

    // A refused pop only happens on an empty deque and removes nothing
    a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_EMPTY_ERR |-> is_empty && popped_value == '0)
        else $error("refused pop with nonempty deque or nonzero value");

    // A refused push only happens on a full deque
    a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL_ERR |-> is_full && !is_empty)
        else $error("refused push while not full");

    // An empty deque shows zero at both ends
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_empty |-> front_value == '0 && back_value == '0)
        else $error("empty deque shows nonzero end value");

    // A valid result stays valid until its transfer
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped before transfer");

endmodule

bind double_ended_queue_top deq_chk u_deq_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .popped_value (rsp.popped_value),
    .front_value  (rsp.front_value),
    .back_value   (rsp.back_value),
    .is_empty     (rsp.is_empty),
    .is_full      (rsp.is_full),
    .status       (rsp.status)
);
